### rtl/lpdf_pkg.sv
package lpdf_pkg;

  // Register indexes on the configuration port.
  localparam logic REG_BOARD_ID  = 1'b0;
  localparam logic REG_INTENSITY = 1'b1;

  // Result kinds.
  localparam logic KIND_SERIAL = 1'b0;
  localparam logic KIND_STRIP  = 1'b1;

  // Frame bytes and reset brightness.
  localparam logic [7:0] START_BYTE      = 8'h00;
  localparam logic [7:0] END_BYTE        = 8'hFF;
  localparam logic [7:0] INTENSITY_RESET = 8'hCC;

  // Division of a byte by three: (b * 171) >> 9 is exact for all 8-bit b.
  localparam logic [7:0] DIV3_MUL   = 8'd171;
  localparam int         DIV3_SHIFT = 9;

  // Byte position of the last color within a pixel.
  localparam logic [1:0] LAST_COLOR = 2'd2;

  // Output slots of one command, in emission order.
  localparam int SLOT_COUNT = 8;
  localparam int SLOT_INTEN = 3;
  localparam int SLOT_DATA  = 4;

  // Work handed from the parser to the output sequencer.
  typedef struct packed {
    logic       start_en;
    logic       inten_en;
    logic       data_en;
    logic       data_kind;
    logic       end_en;
    logic [7:0] inten_val;
    logic [7:0] data_val;
  } cmd_t;

  // One result item.
  typedef struct packed {
    logic       kind;
    logic [7:0] value;
    logic       last;
  } res_t;

endpackage

### rtl/lpdf_fifo.sv
module lpdf_fifo #(
  parameter int DATA_W = 8,
  parameter int DEPTH  = 2
) (
  input  logic              clk,
  input  logic              rst_n,
  input  logic              wr_en,
  input  logic [DATA_W-1:0] wr_data,
  output logic              full,
  input  logic              rd_en,
  output logic [DATA_W-1:0] rd_data,
  output logic              empty
);

  localparam int AW = (DEPTH > 1) ? $clog2(DEPTH) : 1;
  localparam int CW = $clog2(DEPTH + 1);
  localparam logic [AW-1:0] LAST_PTR = AW'(DEPTH - 1);
  localparam logic [CW-1:0] FULL_CNT = CW'(DEPTH);

  logic [DATA_W-1:0] mem_r [DEPTH];
  logic [AW-1:0]     wr_ptr_r, wr_ptr_nxt;
  logic [AW-1:0]     rd_ptr_r, rd_ptr_nxt;
  logic [CW-1:0]     cnt_r, cnt_nxt;
  logic              do_wr, do_rd;

  assign full    = (cnt_r == FULL_CNT);
  assign empty   = (cnt_r == '0);
  assign do_wr   = wr_en && !full;
  assign do_rd   = rd_en && !empty;
  assign rd_data = mem_r[rd_ptr_r];

  // Pointer and occupancy update.
  always_comb begin
    wr_ptr_nxt = wr_ptr_r;
    rd_ptr_nxt = rd_ptr_r;
    cnt_nxt    = cnt_r;
    if (do_wr) begin
      wr_ptr_nxt = (wr_ptr_r == LAST_PTR) ? '0 : wr_ptr_r + 1'b1;
    end
    if (do_rd) begin
      rd_ptr_nxt = (rd_ptr_r == LAST_PTR) ? '0 : rd_ptr_r + 1'b1;
    end
    if (do_wr && !do_rd) begin
      cnt_nxt = cnt_r + 1'b1;
    end else if (do_rd && !do_wr) begin
      cnt_nxt = cnt_r - 1'b1;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      wr_ptr_r <= '0;
      rd_ptr_r <= '0;
      cnt_r    <= '0;
    end else begin
      wr_ptr_r <= wr_ptr_nxt;
      rd_ptr_r <= rd_ptr_nxt;
      cnt_r    <= cnt_nxt;
    end
  end

  // Storage needs no reset.
  always_ff @(posedge clk) begin
    if (do_wr) begin
      mem_r[wr_ptr_r] <= wr_data;
    end
  end

endmodule

### rtl/lpdf_front.sv
module lpdf_front
  import lpdf_pkg::*;
(
  input  logic       clk,
  input  logic       rst_n,
  input  logic       accept,
  input  logic [7:0] rx_byte,
  input  logic [7:0] own_board_id,
  input  logic [7:0] intensity,
  output logic       cmd_push,
  output cmd_t       cmd
);

  typedef enum logic [3:0] {
    PH_ID   = 4'b0001,
    PH_SEL  = 4'b0010,
    PH_LEN  = 4'b0100,
    PH_DATA = 4'b1000
  } phase_t;

  phase_t      phase_r, phase_nxt;
  logic        for_us_r, for_us_nxt;
  logic [6:0]  pix_left_r, pix_left_nxt;
  logic [1:0]  color_r, color_nxt;
  logic [15:0] prod;
  logic [6:0]  pix_count;

  // Pixel count is the length byte divided by three.
  assign prod      = 16'(rx_byte) * 16'(DIV3_MUL);
  assign pix_count = prod[DIV3_SHIFT +: 7];

  // Parser: classify the byte and build the command for the sequencer.
  always_comb begin
    phase_nxt    = phase_r;
    for_us_nxt   = for_us_r;
    pix_left_nxt = pix_left_r;
    color_nxt    = color_r;
    cmd          = '0;
    cmd.inten_val = intensity;
    cmd.data_val  = rx_byte;
    cmd.data_kind = KIND_SERIAL;
    unique case (phase_r)
      PH_ID: begin
        for_us_nxt = (rx_byte == own_board_id);
        phase_nxt  = PH_SEL;
      end
      PH_SEL: begin
        cmd.data_en   = 1'b1;
        cmd.data_kind = KIND_STRIP;
        phase_nxt     = PH_LEN;
      end
      PH_LEN: begin
        pix_left_nxt = pix_count;
        color_nxt    = '0;
        cmd.start_en = for_us_r;
        if (pix_count == '0) begin
          cmd.end_en = for_us_r;
          phase_nxt  = PH_ID;
        end else begin
          phase_nxt = PH_DATA;
        end
      end
      PH_DATA: begin
        cmd.inten_en = for_us_r && (color_r == '0);
        cmd.data_en  = for_us_r;
        if (color_r >= LAST_COLOR) begin
          color_nxt    = '0;
          pix_left_nxt = pix_left_r - 1'b1;
          if (pix_left_r == 7'd1) begin
            cmd.end_en = for_us_r;
            phase_nxt  = PH_ID;
          end
        end else begin
          color_nxt = color_r + 1'b1;
        end
      end
      default: begin
        phase_nxt = PH_ID;
      end
    endcase
  end

  // Only commands that produce output go into the queue.
  assign cmd_push = accept && (cmd.start_en || cmd.inten_en || cmd.data_en || cmd.end_en);

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      phase_r    <= PH_ID;
      for_us_r   <= 1'b0;
      pix_left_r <= '0;
      color_r    <= '0;
    end else if (accept) begin
      phase_r    <= phase_nxt;
      for_us_r   <= for_us_nxt;
      pix_left_r <= pix_left_nxt;
      color_r    <= color_nxt;
    end
  end

endmodule

### rtl/lpdf_back.sv
module lpdf_back
  import lpdf_pkg::*;
(
  input  logic clk,
  input  logic rst_n,
  input  logic cmd_empty,
  input  cmd_t cmd_in,
  output logic cmd_pop,
  input  logic res_full,
  output logic res_push,
  output res_t res
);

  logic [SLOT_COUNT-1:0] rem_r, rem_nxt;
  logic [SLOT_COUNT-1:0] low;
  logic [SLOT_COUNT-1:0] rem_after;
  logic [SLOT_COUNT-1:0] load_mask;
  cmd_t                  cur_r;
  logic                  load;

  // Slots still to emit for the incoming command: start frame, intensity,
  // data byte, end frame.
  assign load_mask = {{3{cmd_in.end_en}}, cmd_in.data_en, cmd_in.inten_en,
                      {3{cmd_in.start_en}}};

  // The lowest pending slot is emitted next.
  assign low       = rem_r & (~rem_r + 1'b1);
  assign rem_after = rem_r & ~low;
  assign res_push  = (rem_r != '0) && !res_full;

  // Take the next command once the current one is finished or finishing.
  assign load    = !cmd_empty && ((rem_r == '0) || (res_push && (rem_after == '0)));
  assign cmd_pop = load;

  // Result byte for the current slot.
  always_comb begin
    res.kind  = KIND_SERIAL;
    res.last  = (rem_after == '0);
    if (low[SLOT_INTEN]) begin
      res.value = cur_r.inten_val;
    end else if (low[SLOT_DATA]) begin
      res.value = cur_r.data_val;
      res.kind  = cur_r.data_kind;
    end else if (|low[2:0]) begin
      res.value = START_BYTE;
    end else begin
      res.value = END_BYTE;
    end
  end

  always_comb begin
    rem_nxt = rem_r;
    if (load) begin
      rem_nxt = load_mask;
    end else if (res_push) begin
      rem_nxt = rem_after;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      rem_r <= '0;
    end else begin
      rem_r <= rem_nxt;
    end
  end

  always_ff @(posedge clk) begin
    if (load) begin
      cur_r <= cmd_in;
    end
  end

endmodule

### rtl/led_packet_demux_framer_top.sv
// LED packet framer. Bytes of the packet stream enter through the push/full
// port, one per cycle while the command queue has room. A parser classifies
// each byte (board id, strip select, length, pixel payload) and queues a
// command; a sequencer behind the queue expands it into result items, one
// item per cycle while there is room into a small output queue read through
// empty/pop. The sequencer's single output per cycle sets the sustained rate:
// a matched pixel byte that opens a pixel yields two items and other bytes
// one, a matched length byte yields three items for each frame it emits, and
// the closing pixel byte of a matched packet three more for its end frame.
// Each result passes the command queue, the sequencer's registers and
// the output queue. Registers: board id at address 0 (reset 0), intensity
// at address 4 (reset 0xCC); write them only while the block is idle.
module led_packet_demux_framer_top
  import lpdf_pkg::*;
#(
  parameter int CMD_DEPTH = 2,
  parameter int OUT_DEPTH = 2
) (
  input  logic        clk,
  input  logic        rst_n,
  input  logic        push,
  output logic        full,
  input  logic [7:0]  in_rx_byte,
  output logic        empty,
  input  logic        pop,
  output logic        out_kind,
  output logic [7:0]  out_value,
  output logic        out_last,
  input  logic        psel,
  input  logic        penable,
  input  logic        pwrite,
  input  logic [2:0]  paddr,
  input  logic [31:0] pwdata,
  output logic [31:0] prdata,
  output logic        pready
);

  logic [7:0] own_board_id_r;
  logic [7:0] intensity_r;
  logic       cfg_wr;
  logic       accept;
  logic       cmd_push;
  cmd_t       cmd_wr;
  cmd_t       cmd_rd;
  logic       cmd_empty;
  logic       cmd_pop;
  logic       res_full;
  logic       res_push;
  res_t       res_wr;
  res_t       res_rd;

  // Configuration registers.
  assign pready = 1'b1;
  assign cfg_wr = psel && penable && pwrite;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      own_board_id_r <= '0;
      intensity_r    <= INTENSITY_RESET;
    end else if (cfg_wr) begin
      case (paddr[2])
        REG_BOARD_ID:  own_board_id_r <= pwdata[7:0];
        REG_INTENSITY: intensity_r    <= pwdata[7:0];
        default:       ;
      endcase
    end
  end

  always_comb begin
    case (paddr[2])
      REG_BOARD_ID:  prdata = {24'd0, own_board_id_r};
      REG_INTENSITY: prdata = {24'd0, intensity_r};
      default:       prdata = '0;
    endcase
  end

  // Input transfer: the parser is ready while the command queue has room.
  assign accept = push && !full;

  lpdf_front u_front (
    .clk          (clk),
    .rst_n        (rst_n),
    .accept       (accept),
    .rx_byte      (in_rx_byte),
    .own_board_id (own_board_id_r),
    .intensity    (intensity_r),
    .cmd_push     (cmd_push),
    .cmd          (cmd_wr)
  );

  // Command queue between parser and sequencer.
  lpdf_fifo #(
    .DATA_W ($bits(cmd_t)),
    .DEPTH  (CMD_DEPTH)
  ) u_cmd_q (
    .clk     (clk),
    .rst_n   (rst_n),
    .wr_en   (cmd_push),
    .wr_data (cmd_wr),
    .full    (full),
    .rd_en   (cmd_pop),
    .rd_data (cmd_rd),
    .empty   (cmd_empty)
  );

  lpdf_back u_back (
    .clk       (clk),
    .rst_n     (rst_n),
    .cmd_empty (cmd_empty),
    .cmd_in    (cmd_rd),
    .cmd_pop   (cmd_pop),
    .res_full  (res_full),
    .res_push  (res_push),
    .res       (res_wr)
  );

  // Output queue holding finished results until their transfer.
  lpdf_fifo #(
    .DATA_W ($bits(res_t)),
    .DEPTH  (OUT_DEPTH)
  ) u_out_q (
    .clk     (clk),
    .rst_n   (rst_n),
    .wr_en   (res_push),
    .wr_data (res_wr),
    .full    (res_full),
    .rd_en   (pop),
    .rd_data (res_rd),
    .empty   (empty)
  );

  assign out_kind  = res_rd.kind;
  assign out_value = res_rd.value;
  assign out_last  = res_rd.last;

endmodule

### tb/sv/tb.sv
module tb;
  timeunit 1ns;
  timeprecision 1ps;

  import lpdf_pkg::*;

  localparam int PIXEL_BYTES = 3;
  localparam int QUIET_CYCLES = 12;
  localparam int DRAIN_LIMIT = 20000;
  localparam int PHASE_ITEMS = 35;
  localparam int MAX_PRINTED = 100;

  // Encoded {kind, value} pairs for the frame bytes.
  localparam logic [8:0] S_START = {KIND_SERIAL, START_BYTE};
  localparam logic [8:0] S_END = {KIND_SERIAL, END_BYTE};

  typedef enum logic [1:0] {P_ID, P_SEL, P_LEN, P_PIXELS} parse_phase_e;

  logic        clk;
  logic        rst_n;
  logic        push;
  logic        full;
  logic [7:0]  in_rx_byte;
  logic        empty;
  logic        pop;
  logic        out_kind;
  logic [7:0]  out_value;
  logic        out_last;
  logic        psel;
  logic        penable;
  logic        pwrite;
  logic [2:0]  paddr;
  logic [31:0] pwdata;
  logic [31:0] prdata;
  logic        pready;

  // Framer state mirrored by the testbench.
  parse_phase_e fr_phase;
  logic         fr_for_us;
  logic [6:0]   fr_pixels;
  logic [1:0]   fr_color;
  logic [7:0]   cfg_board_id;
  logic [7:0]   cfg_intensity;

  res_t step_outputs[$];
  res_t due_outputs[$];

  // Directed stimulus table: byte, typed result count (-1 means predicted) and
  // typed results as 9-bit {kind, value} pairs, the first one in the low bits.
  logic [7:0]  dir_byte[$];
  int          dir_n[$];
  logic [53:0] dir_exp[$];

  int send_idle_pct;
  int recv_idle_pct;
  int fail_count;
  int items_sent;
  int results_seen;
  int own_packets;
  int other_packets;

  led_packet_demux_framer_top DUT (
    .clk        (clk),
    .rst_n      (rst_n),
    .push       (push),
    .full       (full),
    .in_rx_byte (in_rx_byte),
    .empty      (empty),
    .pop        (pop),
    .out_kind   (out_kind),
    .out_value  (out_value),
    .out_last   (out_last),
    .psel       (psel),
    .penable    (penable),
    .pwrite     (pwrite),
    .paddr      (paddr),
    .pwdata     (pwdata),
    .prdata     (prdata),
    .pready     (pready)
  );

  // Clock with a 20 ns period.
  always begin
    clk = 1'b0;
    #10;
    clk = 1'b1;
    #10;
  end

  task automatic flag_mismatch(input string what);
    fail_count++;
    if (fail_count <= MAX_PRINTED) begin
      $display("[%0t] MISMATCH: %s", $time, what);
    end
  endtask

  // Queues one serial byte or strip select update for the current input byte.
  function automatic void emit(input logic kind, input logic [7:0] value);
    res_t r;
    r.kind = kind;
    r.value = value;
    r.last = 1'b0;
    step_outputs.push_back(r);
  endfunction

  function automatic void emit_frame(input logic [7:0] value);
    for (int i = 0; i < 3; i++) begin
      emit(KIND_SERIAL, value);
    end
  endfunction

  // Advances the framer state by one received byte and collects its outputs.
  function automatic void frame_rx_byte(input logic [7:0] b);
    res_t r;
    step_outputs.delete();
    case (fr_phase)
      P_ID: begin
        fr_for_us = (b == cfg_board_id);
        if (fr_for_us) own_packets++;
        else other_packets++;
        fr_phase = P_SEL;
      end
      P_SEL: begin
        emit(KIND_STRIP, b);
        fr_phase = P_LEN;
      end
      P_LEN: begin
        fr_pixels = 7'(b / PIXEL_BYTES);
        fr_color = '0;
        if (fr_for_us) emit_frame(START_BYTE);
        if (fr_pixels == '0) begin
          if (fr_for_us) emit_frame(END_BYTE);
          fr_phase = P_ID;
        end else begin
          fr_phase = P_PIXELS;
        end
      end
      default: begin
        if (fr_for_us) begin
          if (fr_color == '0) emit(KIND_SERIAL, cfg_intensity);
          emit(KIND_SERIAL, b);
        end
        if (fr_color >= LAST_COLOR) begin
          fr_color = '0;
          fr_pixels = fr_pixels - 7'd1;
          if (fr_pixels == '0) begin
            if (fr_for_us) emit_frame(END_BYTE);
            fr_phase = P_ID;
          end
        end else begin
          fr_color = fr_color + 2'd1;
        end
      end
    endcase
    if (step_outputs.size() > 0) begin
      r = step_outputs.pop_back();
      r.last = 1'b1;
      step_outputs.push_back(r);
    end
  endfunction

  // Offers one byte, waits for its transfer, then records what it must produce.
  task automatic send_byte(input logic [7:0] b, input int typed_n, input logic [53:0] typed);
    res_t r;
    while ($urandom_range(99) < send_idle_pct) begin
      push <= 1'b0;
      @(posedge clk);
    end
    push <= 1'b1;
    in_rx_byte <= b;
    @(posedge clk);
    while (full !== 1'b0) @(posedge clk);
    items_sent++;
    frame_rx_byte(b);
    if (typed_n >= 0) begin
      for (int i = 0; i < typed_n; i++) begin
        r.kind = typed[9*i+8];
        r.value = typed[9*i +: 8];
        r.last = (i == typed_n - 1);
        due_outputs.push_back(r);
      end
    end else begin
      foreach (step_outputs[i]) due_outputs.push_back(step_outputs[i]);
    end
  endtask

  task automatic feed(input logic [7:0] b);
    send_byte(b, -1, '0);
  endtask

  task automatic add_row(input logic [7:0] b, input int n, input logic [53:0] typed);
    dir_byte.push_back(b);
    dir_n.push_back(n);
    dir_exp.push_back(typed);
  endtask

  // Waits until every expected result is out and the parser has gone quiet.
  task automatic wait_quiet();
    push <= 1'b0;
    while (due_outputs.size() != 0) @(posedge clk);
    repeat (QUIET_CYCLES) @(posedge clk);
  endtask

  // Register write followed by a read back of the same register.
  task automatic write_reg(input logic idx, input logic [7:0] val);
    psel <= 1'b1;
    penable <= 1'b0;
    pwrite <= 1'b1;
    paddr <= {idx, 2'b00};
    pwdata <= {24'b0, val};
    @(posedge clk);
    penable <= 1'b1;
    @(posedge clk);
    while (pready !== 1'b1) @(posedge clk);
    if (idx == REG_BOARD_ID) cfg_board_id = val;
    else cfg_intensity = val;
    penable <= 1'b0;
    pwrite <= 1'b0;
    @(posedge clk);
    penable <= 1'b1;
    @(posedge clk);
    while (pready !== 1'b1) @(posedge clk);
    if (prdata !== {24'b0, val}) begin
      flag_mismatch($sformatf("register %0d read 0x%08h, wrote 0x%02h", idx, prdata, val));
    end
    psel <= 1'b0;
    penable <= 1'b0;
    @(posedge clk);
  endtask

  // One packet with random content; a length that is not a multiple of three
  // lets the stray bytes start the next header, which is then completed.
  task automatic send_packet(input bit to_us, input int fixed_len);
    logic [7:0] len;
    int pick;
    if (to_us) feed(cfg_board_id);
    else feed(8'($urandom_range(255)));
    feed(8'($urandom_range(255)));
    if (fixed_len >= 0) begin
      len = 8'(fixed_len);
    end else begin
      pick = $urandom_range(99);
      if (pick < 75) len = 8'($urandom_range(20));
      else if (pick < 95) len = 8'($urandom_range(60, 21));
      else len = 8'($urandom_range(255, 61));
      if ($urandom_range(3) != 0) len = len - 8'(len % PIXEL_BYTES);
    end
    feed(len);
    for (int k = 0; k < len; k++) feed(8'($urandom_range(255)));
    while (fr_phase != P_ID) begin
      if (fr_phase == P_LEN) feed(8'($urandom_range(20)));
      else feed(8'($urandom_range(255)));
    end
  endtask

  task automatic random_phase(input int target, input bit with_longest);
    int start;
    start = items_sent;
    if (with_longest) send_packet(1'b1, 255);
    while (items_sent - start < target) begin
      send_packet($urandom_range(99) < 60, -1);
    end
  endtask

  // Result side: pops at random and checks each transfer against the oldest
  // expectation.
  initial begin
    res_t want;
    pop <= 1'b0;
    forever begin
      @(posedge clk);
      if (rst_n && pop && empty === 1'b0) begin
        results_seen++;
        if (due_outputs.size() == 0) begin
          flag_mismatch($sformatf("unexpected result kind %0d value 0x%02h last %0d",
                                  out_kind, out_value, out_last));
        end else begin
          want = due_outputs.pop_front();
          if (out_kind !== want.kind) begin
            flag_mismatch($sformatf("kind %0d, expected %0d", out_kind, want.kind));
          end
          if (out_value !== want.value) begin
            flag_mismatch($sformatf("value 0x%02h, expected 0x%02h", out_value, want.value));
          end
          if (out_last !== want.last) begin
            flag_mismatch($sformatf("last %0d, expected %0d", out_last, want.last));
          end
        end
      end
      pop <= ($urandom_range(99) >= recv_idle_pct);
    end
  end

  // Hard stop in case the block hangs.
  initial begin
    #5_000_000;
    $display("Test completed with failures");
    $finish;
  end

  initial begin
    rst_n <= 1'b0;
    push <= 1'b0;
    in_rx_byte <= '0;
    psel <= 1'b0;
    penable <= 1'b0;
    pwrite <= 1'b0;
    paddr <= '0;
    pwdata <= '0;
    fail_count = 0;
    items_sent = 0;
    results_seen = 0;
    own_packets = 0;
    other_packets = 0;
    send_idle_pct = 9;
    recv_idle_pct = 50;
    fr_phase = P_ID;
    fr_for_us = 1'b0;
    fr_pixels = '0;
    fr_color = '0;
    cfg_board_id = '0;
    cfg_intensity = INTENSITY_RESET;

    // Reset values: board 0 answers, intensity 0xCC.
    // Matched packet with zero length: start frame straight into end frame.
    add_row(8'h00, 0, '0);
    add_row(8'h5A, 1, {KIND_STRIP, 8'h5A});
    add_row(8'h00, 6, {S_END, S_END, S_END, S_START, S_START, S_START});
    // Length 4 is one pixel; the fourth byte becomes the next board id.
    add_row(8'h00, 0, '0);
    add_row(8'hFF, 1, {KIND_STRIP, 8'hFF});
    add_row(8'h04, 3, {S_START, S_START, S_START});
    add_row(8'h00, 2, {KIND_SERIAL, 8'h00, KIND_SERIAL, INTENSITY_RESET});
    add_row(8'hFF, 1, {KIND_SERIAL, 8'hFF});
    add_row(8'h80, 4, {S_END, S_END, S_END, KIND_SERIAL, 8'h80});
    // Packet for another board: only the strip select comes out.
    add_row(8'h01, 0, '0);
    add_row(8'h00, 1, {KIND_STRIP, 8'h00});
    add_row(8'h06, 0, '0);
    add_row(8'h11, -1, '0);
    add_row(8'h22, -1, '0);
    add_row(8'h33, -1, '0);
    add_row(8'hFF, -1, '0);
    add_row(8'h00, -1, '0);
    add_row(8'h7F, -1, '0);
    // Nonzero length below one pixel.
    add_row(8'h00, -1, '0);
    add_row(8'h33, -1, '0);
    add_row(8'h02, -1, '0);
    // Exactly one pixel.
    add_row(8'h00, -1, '0);
    add_row(8'hC3, -1, '0);
    add_row(8'h03, -1, '0);
    add_row(8'h01, -1, '0);
    add_row(8'h02, -1, '0);
    add_row(8'h03, -1, '0);

    repeat (3) @(posedge clk);
    rst_n <= 1'b1;
    @(posedge clk);

    for (int k = 0; k < dir_byte.size(); k++) begin
      send_byte(dir_byte[k], dir_n[k], dir_exp[k]);
    end
    wait_quiet();

    // Sender mostly busy, receiver stalling half the time; extreme registers.
    write_reg(REG_BOARD_ID, 8'hFF);
    write_reg(REG_INTENSITY, 8'h00);
    random_phase(PHASE_ITEMS, 1'b0);
    wait_quiet();

    // Sender idling half the time, receiver mostly popping.
    send_idle_pct = 50;
    recv_idle_pct = 9;
    write_reg(REG_BOARD_ID, 8'h00);
    write_reg(REG_INTENSITY, 8'hFF);
    random_phase(PHASE_ITEMS, 1'b0);
    wait_quiet();

    // Full throughput on both sides, including the longest packet.
    send_idle_pct = 0;
    recv_idle_pct = 0;
    write_reg(REG_BOARD_ID, 8'($urandom_range(255)));
    write_reg(REG_INTENSITY, 8'($urandom_range(255)));
    random_phase(PHASE_ITEMS, 1'b1);
    push <= 1'b0;

    // Drain, then give stray results time to show up.
    for (int i = 0; i < DRAIN_LIMIT && due_outputs.size() != 0; i++) @(posedge clk);
    if (due_outputs.size() != 0) begin
      flag_mismatch($sformatf("%0d expected results never arrived", due_outputs.size()));
    end
    repeat (QUIET_CYCLES) @(posedge clk);

    $display("Fed %0d bytes and checked %0d results under four register settings.",
             items_sent, results_seen);
    $display("Packets parsed: %0d for this board, %0d for other boards.",
             own_packets, other_packets);
    if (fail_count == 0) begin
      $display("Test completed successfully");
    end else begin
      $display("Test completed with failures");
    end
    $finish;
  end

endmodule
